>>> rtl/gsp_pkg.sv
// shared types, constants and helper functions for the gcr sector payload encoder
// no dependencies
package gsp_pkg;

  localparam int PAYLOAD_BYTES = 524;
  localparam int POS_W = 10;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PAYLOAD_BYTES - 1);

  localparam logic [2:0] TRIPLE_LAST_IDX = 3'd3;
  localparam logic [2:0] FINAL_LAST_IDX = 3'd6;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  typedef enum logic {
    JOB_TRIPLE = 1'b0,
    JOB_FINAL  = 1'b1
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] sa;
    logic [7:0] sb;
    logic [7:0] sc;
  } job_t;

  localparam logic [7:0] GCR_TABLE [64] = '{
    8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
    8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
    8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
    8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
    8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
    8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
    8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
    8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
  };

  function automatic logic [7:0] gcr_code(input logic [5:0] six);
    return GCR_TABLE[six];
  endfunction

  function automatic logic [5:0] pack_top(input logic [7:0] x, input logic [7:0] y,
                                          input logic [7:0] z);
    return {x[7:6], y[7:6], z[7:6]};
  endfunction

endpackage

>>> rtl/gsp_front.sv
// front end: accepts payload bytes, runs the three checksums and whitening
// builds triple and final-group jobs; depends on gsp_pkg
module gsp_front import gsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_payload_byte,
  input  logic       q_full,
  output logic       push,
  output job_t       push_job
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  phase_t           phase_r, phase_nxt;
  logic [8:0]       sum_a_r, sum_a_nxt;
  logic [8:0]       sum_b_r, sum_b_nxt;
  logic [8:0]       sum_c_r, sum_c_nxt;
  logic [7:0]       held_first_r, held_first_nxt;
  logic [7:0]       held_second_r, held_second_nxt;
  logic             needs_push;
  logic             accept;
  logic [7:0]       w;

  assign needs_push = (phase_r == PH_THIRD) || (pos_r == LAST_POS);
  assign in_ready   = !q_full || !needs_push;
  assign accept     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      phase_r       <= PH_FIRST;
      sum_a_r       <= '0;
      sum_b_r       <= '0;
      sum_c_r       <= '0;
      held_first_r  <= '0;
      held_second_r <= '0;
    end else begin
      pos_r         <= pos_nxt;
      phase_r       <= phase_nxt;
      sum_a_r       <= sum_a_nxt;
      sum_b_r       <= sum_b_nxt;
      sum_c_r       <= sum_c_nxt;
      held_first_r  <= held_first_nxt;
      held_second_r <= held_second_nxt;
    end
  end

  always_comb begin
    pos_nxt         = pos_r;
    phase_nxt       = phase_r;
    sum_a_nxt       = sum_a_r;
    sum_b_nxt       = sum_b_r;
    sum_c_nxt       = sum_c_r;
    held_first_nxt  = held_first_r;
    held_second_nxt = held_second_r;
    w               = '0;
    push            = 1'b0;
    push_job        = '0;
    if (accept) begin
      unique case (phase_r)
        PH_FIRST: begin
          // rotate left, carry out feeds sum_c
          sum_a_nxt      = {1'b0, sum_a_r[6:0], sum_a_r[7]};
          sum_c_nxt      = sum_c_r + {1'b0, in_payload_byte} + {8'd0, sum_a_r[7]};
          held_first_nxt = in_payload_byte ^ sum_a_nxt[7:0];
          phase_nxt      = PH_SECOND;
        end
        PH_SECOND: begin
          sum_b_nxt       = sum_b_r + {1'b0, in_payload_byte} + {8'd0, sum_c_r[8]};
          sum_c_nxt       = {1'b0, sum_c_r[7:0]};
          held_second_nxt = in_payload_byte ^ sum_c_r[7:0];
          phase_nxt       = PH_THIRD;
        end
        PH_THIRD: begin
          sum_a_nxt     = sum_a_r + {1'b0, in_payload_byte} + {8'd0, sum_b_r[8]};
          sum_b_nxt     = {1'b0, sum_b_r[7:0]};
          w             = in_payload_byte ^ sum_b_r[7:0];
          push          = 1'b1;
          push_job.kind = JOB_TRIPLE;
          push_job.b0   = held_first_r;
          push_job.b1   = held_second_r;
          push_job.b2   = w;
          phase_nxt     = PH_FIRST;
        end
        default: begin
          phase_nxt = PH_FIRST;
        end
      endcase

      if (pos_r == LAST_POS) begin
        push          = 1'b1;
        push_job.kind = JOB_FINAL;
        push_job.b0   = held_first_nxt;
        push_job.b1   = held_second_nxt;
        push_job.b2   = '0;
        push_job.sa   = sum_a_nxt[7:0];
        push_job.sb   = sum_b_nxt[7:0];
        push_job.sc   = sum_c_nxt[7:0];
        // end of sector: back to reset state
        pos_nxt         = '0;
        phase_nxt       = PH_FIRST;
        sum_a_nxt       = '0;
        sum_b_nxt       = '0;
        sum_c_nxt       = '0;
        held_first_nxt  = '0;
        held_second_nxt = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

endmodule

>>> rtl/gsp_queue.sv
// two-entry job queue between front and back
// depends on gsp_pkg
module gsp_queue import gsp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign empty = (count_r == 2'd0);
  assign full  = (count_r == 2'd2);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

>>> rtl/gsp_back.sv
// back end: walks the head job and emits one gcr disk byte per beat
// depends on gsp_pkg
module gsp_back import gsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head,
  input  logic       q_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_disk_byte,
  output logic       out_last_of_sector
);

  logic [2:0] idx_r, idx_nxt;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       advance;
  logic       emit;
  logic       at_end;
  logic [2:0] end_idx;
  logic [5:0] six;

  assign advance = !valid_r || out_ready;
  assign emit    = advance && !q_empty;
  assign end_idx = (head.kind == JOB_FINAL) ? FINAL_LAST_IDX : TRIPLE_LAST_IDX;
  assign at_end  = (idx_r == end_idx);
  assign pop     = emit && at_end;
  assign idx_nxt = at_end ? 3'd0 : idx_r + 3'd1;

  always_comb begin
    case (idx_r)
      3'd0:    six = pack_top(head.b0, head.b1, head.b2);
      3'd1:    six = head.b0[5:0];
      3'd2:    six = head.b1[5:0];
      3'd3:    six = (head.kind == JOB_FINAL) ? pack_top(head.sc, head.sb, head.sa)
                                              : head.b2[5:0];
      3'd4:    six = head.sc[5:0];
      3'd5:    six = head.sb[5:0];
      3'd6:    six = head.sa[5:0];
      default: six = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (emit) begin
        idx_r <= idx_nxt;
      end
      if (advance) begin
        valid_r <= !q_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= gcr_code(six);
      last_r <= (head.kind == JOB_FINAL) && at_end;
    end
  end

  assign out_valid          = valid_r;
  assign out_disk_byte      = byte_r;
  assign out_last_of_sector = last_r;

endmodule

>>> rtl/gcr_sector_payload_encoder_core.sv
// top level: 6-and-2 gcr sector payload encoder, one payload byte in, disk bytes out
// a triple's job goes through the job queue and the back's output register; throughput:
// one payload byte in and one disk byte out per cycle when neither side stalls; 703 disk
// bytes per 524-byte sector, so the back's output register sets the rate
// reset (rst_n low, synchronous) clears checksums, byte position, job queue and output
module gcr_sector_payload_encoder_core import gsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_payload_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_disk_byte,
  output logic       out_last_of_sector
);

  logic q_push;
  job_t q_push_job;
  logic q_pop;
  job_t q_head;
  logic q_empty;
  logic q_full;

  gsp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_payload_byte (in_payload_byte),
    .q_full          (q_full),
    .push            (q_push),
    .push_job        (q_push_job)
  );

  gsp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  gsp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (q_head),
    .q_empty            (q_empty),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_disk_byte      (out_disk_byte),
    .out_last_of_sector (out_last_of_sector)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full && !q_pop))
    else $error("job pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty))
    else $error("job popped from empty queue");

  a_final_job_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.kind == JOB_FINAL) |=> (out_valid && out_last_of_sector))
    else $error("final job did not end with last beat");

endmodule

>>> dv/tb_top.sv
// self-checking testbench for gcr_sector_payload_encoder_core: payload beats in, gcr disk bytes out
// depends on rtl/gsp_pkg.sv (phase_t) and the core rtl; a local predictor sets the expected bytes
module tb_top import gsp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SECTOR_BYTES = 524;
  localparam int DIRECTED_LEN = 24;
  localparam int ITEM_COUNT = 100;
  localparam int MAX_REPORTS = 10;

  localparam logic [1:0] READY_ALWAYS = 2'd0;
  localparam logic [1:0] READY_RANDOM = 2'd1;
  localparam logic [1:0] READY_SPARSE = 2'd2;

  localparam logic [7:0] GCR_CODES [64] = '{
    8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
    8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
    8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
    8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
    8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
    8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
    8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
    8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
  };

  typedef struct packed {
    logic [7:0] disk_byte;
    logic       last_of_sector;
  } disk_beat_t;

  typedef struct packed {
    logic [7:0]  payload;
    logic        typed;
    logic [31:0] typed_bytes;
  } stim_row_t;

  // typed rows: all-zero triple after reset, then all-ones triple on zero sums
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    '{8'h00, 1'b0, 32'h0}, '{8'h00, 1'b0, 32'h0}, '{8'h00, 1'b1, 32'h96969696},
    '{8'hFF, 1'b0, 32'h0}, '{8'hFF, 1'b0, 32'h0}, '{8'hFF, 1'b1, 32'hEDFF9696},
    '{8'h80, 1'b0, 32'h0}, '{8'h01, 1'b0, 32'h0}, '{8'h7F, 1'b0, 32'h0},
    '{8'hAA, 1'b0, 32'h0}, '{8'h55, 1'b0, 32'h0}, '{8'hAA, 1'b0, 32'h0},
    '{8'h55, 1'b0, 32'h0}, '{8'hAA, 1'b0, 32'h0}, '{8'h55, 1'b0, 32'h0},
    '{8'hFE, 1'b0, 32'h0}, '{8'hFD, 1'b0, 32'h0}, '{8'hFB, 1'b0, 32'h0},
    '{8'hF7, 1'b0, 32'h0}, '{8'hEF, 1'b0, 32'h0}, '{8'hDF, 1'b0, 32'h0},
    '{8'hBF, 1'b0, 32'h0}, '{8'h40, 1'b0, 32'h0}, '{8'h20, 1'b0, 32'h0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_payload_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_disk_byte;
  logic       out_last_of_sector;

  disk_beat_t disk_byte_q[$];
  disk_beat_t step_results[$];
  int         mismatches = 0;
  int         burst_left = 0;

  logic [9:0] byte_pos;
  logic [8:0] sum_a, sum_b, sum_c;
  logic [7:0] held_first, held_second;

  logic [1:0] stall_mode = READY_ALWAYS;
  logic [7:0] stall_cyc = '0;

  gcr_sector_payload_encoder_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_payload_byte   (in_payload_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_disk_byte     (out_disk_byte),
    .out_last_of_sector(out_last_of_sector)
  );

  always #6 clk = ~clk;

  function automatic logic [5:0] top_pairs(input logic [7:0] x, input logic [7:0] y,
                                           input logic [7:0] z);
    return {x[7:6], y[7:6], z[7:6]};
  endfunction

  task automatic clear_sector_state();
    byte_pos = '0;
    sum_a = '0;
    sum_b = '0;
    sum_c = '0;
    held_first = '0;
    held_second = '0;
  endtask

  task automatic emit_six(input logic [5:0] six, input logic last);
    step_results.insert(step_results.size(), disk_beat_t'{GCR_CODES[six], last});
  endtask

  task automatic encode_payload_byte(input logic [7:0] b);
    logic [7:0] third;
    phase_t     phase;
    step_results.delete();
    phase = phase_t'(2'(byte_pos % 3));
    case (phase)
      PH_FIRST: begin
        // rotate left, carry out goes into sum_c
        sum_a = {sum_a[7:0], 1'b0};
        if (sum_a[8]) sum_a = sum_a + 9'd1;
        sum_c = sum_c + b;
        if (sum_a[8]) begin
          sum_c = sum_c + 9'd1;
          sum_a[8] = 1'b0;
        end
        held_first = b ^ sum_a[7:0];
      end
      PH_SECOND: begin
        sum_b = sum_b + b;
        if (sum_c[8]) begin
          sum_b = sum_b + 9'd1;
          sum_c[8] = 1'b0;
        end
        held_second = b ^ sum_c[7:0];
      end
      default: begin
        sum_a = sum_a + b;
        if (sum_b[8]) begin
          sum_a = sum_a + 9'd1;
          sum_b[8] = 1'b0;
        end
        third = b ^ sum_b[7:0];
        emit_six(top_pairs(held_first, held_second, third), 1'b0);
        emit_six(held_first[5:0], 1'b0);
        emit_six(held_second[5:0], 1'b0);
        emit_six(third[5:0], 1'b0);
      end
    endcase
    if (byte_pos == 10'(SECTOR_BYTES - 1)) begin
      // half group then checksum bytes
      emit_six(top_pairs(held_first, held_second, 8'h00), 1'b0);
      emit_six(held_first[5:0], 1'b0);
      emit_six(held_second[5:0], 1'b0);
      emit_six(top_pairs(sum_c[7:0], sum_b[7:0], sum_a[7:0]), 1'b0);
      emit_six(sum_c[5:0], 1'b0);
      emit_six(sum_b[5:0], 1'b0);
      emit_six(sum_a[5:0], 1'b1);
      clear_sector_state();
    end else begin
      byte_pos = byte_pos + 10'd1;
    end
  endtask

  task automatic send_payload(input logic [7:0] b, input logic typed,
                              input logic [31:0] typed_bytes);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_payload_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    encode_payload_byte(b);
    if (typed) begin
      for (int k = 0; k < 4; k++)
        disk_byte_q.insert(disk_byte_q.size(),
                           disk_beat_t'{typed_bytes[31 - 8*k -: 8], 1'b0});
    end else begin
      foreach (step_results[k]) disk_byte_q.insert(disk_byte_q.size(), step_results[k]);
    end
  endtask

  function automatic logic [7:0] random_payload();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %0s at %0t: expected %h actual %h", what, $time, want, got);
  endtask

  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 8'd1;
    if (stall_cyc[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 2));
    case (stall_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      READY_SPARSE: out_ready <= (stall_cyc[1:0] == 2'd0);
      default: out_ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    disk_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (disk_byte_q.size() == 0) begin
        flag_mismatch("unexpected beat", 8'h00, out_disk_byte);
      end else begin
        want = disk_byte_q.pop_front();
        if (out_disk_byte !== want.disk_byte)
          flag_mismatch("disk_byte", want.disk_byte, out_disk_byte);
        if (out_last_of_sector !== want.last_of_sector)
          flag_mismatch("last_of_sector", 8'(want.last_of_sector), 8'(out_last_of_sector));
      end
    end
  end

  initial begin
    int random_count;
    clear_sector_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED_ROWS[i])
      send_payload(DIRECTED_ROWS[i].payload, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].typed_bytes);
    // random payload up to the item count
    random_count = ITEM_COUNT - DIRECTED_LEN;
    for (int i = 0; i < random_count; i++) send_payload(random_payload(), 1'b0, 32'h0);
    in_valid <= 1'b0;
    while (disk_byte_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
